>>> hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants of the first-fit segment allocator
// Default geometry, field widths, command codes and the words that move
// along the descriptor cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

    // Default geometry
    localparam int POOL_BYTES_DEF    = 4096;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int CLUSTER_BYTES_DEF = 16;
    localparam int MAX_POOLS_DEF     = 8;

    // Port field widths
    localparam int ADDR_W   = 15;
    localparam int REQ_W    = 13;
    localparam int STATUS_W = 2;

    // Widths that cover the whole parameter range
    localparam int IDX_MW  = 9;   // slot index, up to 256 entries plus tail
    localparam int SZ_MW   = 17;  // cluster count, up to 65536
    localparam int POOL_MW = 7;   // pool count, up to 64
    localparam int DIV_W   = 17;  // divider operand width

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } status_t;

    // Table update broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SPLIT,
        OP_EXACT,
        OP_NEW,
        OP_FREE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [POOL_MW-1:0]   pool;
        logic [IDX_MW-1:0]    pos;    // split or merge position
        logic [IDX_MW-1:0]    last;   // entries in use before the update
        logic [1:0]           gap;    // slots removed by a merge
        logic [SZ_MW-1:0]     val;    // new size
    } cmd_t;

    // One descriptor as seen by a neighbor cell
    typedef struct packed {
        logic [SZ_MW-1:0] off;
        logic [SZ_MW-1:0] size;
        logic             used;
    } slot_t;

    // Allocation search word, one lane per pool
    typedef struct packed {
        logic              found;
        logic              exact;
        logic [IDX_MW-1:0] idx;
        logic [SZ_MW-1:0]  off;
        logic              tail;
        logic [SZ_MW-1:0]  toff;
    } fit_t;

    // Free lookup word for the addressed pool
    typedef struct packed {
        logic              found;
        logic              pend;
        logic [IDX_MW-1:0] idx;
        logic              lfree;
        logic [SZ_MW-1:0]  lsize;
        logic [SZ_MW-1:0]  csize;
        logic              rfree;
        logic [SZ_MW-1:0]  rsize;
        logic              pused;
        logic [SZ_MW-1:0]  psize;
    } hit_t;

endpackage

`default_nettype wire

>>> hw/rtl/ffsa_div.sv
// ----------------------------------------------------------------------------
// ffsa_div: constant divider by reciprocal multiplication
// Divides by the pool size or the cluster size; the quotient is registered on
// start, the remainder in the cycle after unless start comes again, and done pulses with it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_div
    import ffsa_pkg::*;
#(
    parameter int DW            = DIV_W,
    parameter int POOL_BYTES    = POOL_BYTES_DEF,
    parameter int CLUSTER_BYTES = CLUSTER_BYTES_DEF
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic          by_pool,
    output logic               done,
    output logic [DW-1:0]      quotient,
    output logic [DW-1:0]      remainder
);

    // Multiplier m = floor(2^(DW+l) / d) + 1 with 2^(l-1) < d <= 2^l gives
    // the exact quotient for every dividend below 2^DW
    localparam int PL_W = $clog2(POOL_BYTES);
    localparam int CL_W = $clog2(CLUSTER_BYTES);
    localparam int PS   = DW + PL_W;
    localparam int CS   = DW + CL_W;
    localparam int MW   = DW + 2;
    localparam int PW   = DW + MW;
    localparam int BW   = 2 * DW;
    localparam logic [MW-1:0] PM = MW'((longint'(1) << PS) / longint'(POOL_BYTES) + 1);
    localparam logic [MW-1:0] CM = MW'((longint'(1) << CS) / longint'(CLUSTER_BYTES) + 1);
    localparam logic [DW-1:0] PD = DW'(POOL_BYTES);
    localparam logic [DW-1:0] CD = DW'(CLUSTER_BYTES);

    logic          step_reg;
    logic          done_reg;
    logic          pool_reg;
    logic [DW-1:0] x_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [MW-1:0] mult;
    logic [PW-1:0] prod;
    logic [DW-1:0] q_now;
    logic [BW-1:0] back;

    // Quotient from the scaled product
    assign mult  = by_pool ? PM : CM;
    assign prod  = PW'(dividend) * PW'(mult);
    assign q_now = by_pool ? DW'(prod >> PS) : DW'(prod >> CS);

    // Multiply back for the remainder
    assign back = BW'(quo_reg) * BW'(pool_reg ? PD : CD);

    // Capture quotient, then remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 1'b0;
            done_reg <= 1'b0;
            pool_reg <= 1'b0;
            x_reg    <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= step_reg && !start;
            if (start)
            begin
                step_reg <= 1'b1;
                pool_reg <= by_pool;
                x_reg    <= dividend;
                quo_reg  <= q_now;
            end
            else if (step_reg)
            begin
                step_reg <= 1'b0;
                rem_reg  <= x_reg - back[DW-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell: one descriptor slot of every pool
// Holds the slot for each pool, advances the search words one cell per
// cycle and applies the broadcast table update using its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter int MAX_POOLS     = MAX_POOLS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int POOL_CLUSTERS = POOL_BYTES_DEF / CLUSTER_BYTES_DEF,
    parameter int CELL_IDX      = 0
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               scan_in,
    output logic                    scan_out,
    input  wire fit_t               fit_in [MAX_POOLS],
    output fit_t                    fit_out [MAX_POOLS],
    input  wire hit_t               hit_in,
    output hit_t                    hit_out,
    input  wire logic [SZ_MW-1:0]   need,
    input  wire logic [IDX_MW-1:0]  counts [MAX_POOLS],
    input  wire logic [POOL_MW-1:0] free_pool,
    input  wire logic [IDX_MW-1:0]  free_count,
    input  wire logic [SZ_MW-1:0]   target,
    input  wire cmd_t               cmd,
    input  wire slot_t              left,
    input  wire slot_t              right1,
    input  wire slot_t              right2,
    output slot_t                   own
);

    localparam int SZ_W = $clog2(POOL_CLUSTERS + 1);
    localparam int PI_W = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int CW   = IDX_MW + 2;
    localparam logic [IDX_MW-1:0] K  = IDX_MW'(CELL_IDX);
    localparam logic [CW-1:0]     KX = CW'(CELL_IDX);

    logic [SZ_W-1:0] off_reg  [MAX_POOLS];
    logic [SZ_W-1:0] size_reg [MAX_POOLS];
    logic            used_reg [MAX_POOLS];

    logic            scan_reg;
    fit_t            fit_reg  [MAX_POOLS];
    fit_t            fit_next [MAX_POOLS];
    hit_t            hit_reg;
    hit_t            hit_next;

    logic [PI_W-1:0]  wp;
    logic [PI_W-1:0]  fp;
    logic             we;
    logic [SZ_MW-1:0] off_next;
    logic [SZ_MW-1:0] size_next;
    logic             used_next;

    assign wp = cmd.pool[PI_W-1:0];
    assign fp = free_pool[PI_W-1:0];

    // Offer this slot to the first-fit and tail search of every pool
    always_comb
    begin
        fit_t             f;
        logic [SZ_MW-1:0] sz;
        for (int q = 0; q < MAX_POOLS; q++)
        begin
            f  = fit_in[q];
            sz = SZ_MW'(size_reg[q]);
            if (K < counts[q] && !f.found && !used_reg[q] && sz >= need)
            begin
                f.found = 1'b1;
                f.exact = (sz == need);
                f.idx   = K;
                f.off   = SZ_MW'(off_reg[q]);
            end
            if (K == counts[q] && counts[q] < IDX_MW'(TABLE_ENTRIES) && sz >= need)
            begin
                f.tail = 1'b1;
                f.toff = SZ_MW'(off_reg[q]);
            end
            fit_next[q] = f;
        end
    end

    // Match the freed offset and capture both neighbors
    always_comb
    begin
        hit_t h;
        h = hit_in;
        if (!h.found && K < free_count && SZ_MW'(off_reg[fp]) == target)
        begin
            h.found = 1'b1;
            h.pend  = 1'b1;
            h.idx   = K;
            h.lfree = (K != '0) && !hit_in.pused;
            h.lsize = hit_in.psize;
            h.csize = SZ_MW'(size_reg[fp]);
        end
        else if (h.pend)
        begin
            h.pend  = 1'b0;
            h.rfree = !used_reg[fp];
            h.rsize = SZ_MW'(size_reg[fp]);
        end
        h.pused  = used_reg[fp];
        h.psize  = SZ_MW'(size_reg[fp]);
        hit_next = h;
    end

    // Apply the broadcast update to the selected pool
    always_comb
    begin
        logic [CW-1:0] px;
        logic [CW-1:0] lx;
        logic [CW-1:0] gx;
        px        = CW'(cmd.pos);
        lx        = CW'(cmd.last);
        gx        = CW'(cmd.gap);
        we        = 1'b0;
        off_next  = SZ_MW'(off_reg[wp]);
        size_next = SZ_MW'(size_reg[wp]);
        used_next = used_reg[wp];
        unique case (cmd.op)
            OP_SPLIT:
            begin
                if (KX == px)
                begin
                    size_next = cmd.val;
                    used_next = 1'b1;
                    we        = 1'b1;
                end
                else if (KX == px + CW'(1))
                begin
                    off_next  = left.off + cmd.val;
                    size_next = left.size - cmd.val;
                    used_next = 1'b0;
                    we        = 1'b1;
                end
                else if (KX > px + CW'(1) && KX <= lx + CW'(1))
                begin
                    off_next  = left.off;
                    size_next = left.size;
                    used_next = left.used;
                    we        = 1'b1;
                end
            end
            OP_EXACT:
            begin
                if (KX == px)
                begin
                    used_next = 1'b1;
                    we        = 1'b1;
                end
            end
            OP_NEW:
            begin
                if (KX == CW'(0))
                begin
                    off_next  = '0;
                    size_next = cmd.val;
                    used_next = 1'b1;
                    we        = 1'b1;
                end
                else if (KX == CW'(1))
                begin
                    off_next  = cmd.val;
                    size_next = SZ_MW'(POOL_CLUSTERS) - cmd.val;
                    used_next = 1'b0;
                    we        = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (KX == px)
                begin
                    size_next = cmd.val;
                    used_next = 1'b0;
                    we        = 1'b1;
                end
                else if (cmd.gap != 2'd0 && KX > px && KX + gx <= lx)
                begin
                    off_next  = (cmd.gap == 2'd1) ? right1.off  : right2.off;
                    size_next = (cmd.gap == 2'd1) ? right1.size : right2.size;
                    used_next = (cmd.gap == 2'd1) ? right1.used : right2.used;
                    we        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold descriptor storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            off_reg[wp]  <= off_next[SZ_W-1:0];
            size_reg[wp] <= size_next[SZ_W-1:0];
            used_reg[wp] <= used_next;
        end
    end

    // Advance the search words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= 1'b0;
        end
        else
        begin
            scan_reg <= scan_in;
        end
    end

    always_ff @(posedge clk)
    begin
        fit_reg <= fit_next;
        hit_reg <= hit_next;
    end

    assign scan_out = scan_reg;
    assign fit_out  = fit_reg;
    assign hit_out  = hit_reg;
    assign own      = '{off: SZ_MW'(off_reg[wp]), size: SZ_MW'(size_reg[wp]),
                        used: used_reg[wp]};

endmodule

`default_nettype wire

>>> hw/rtl/first_fit_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit: first-fit allocator with coalescing
// Pools of descriptor tables kept in a chain of slot cells; requests are
// decoded by a shared constant divider, then one sweep down the chain.
// ----------------------------------------------------------------------------
// Steps: the divider decodes the word (twice for a free), then a launch and the
//   sweep of TABLE_ENTRIES + 1 cells, then an update step before done when the
//   word succeeds; a bad size or pool ends after the first division, an
//   unaligned free after the second. Throughput: one word at a time, the next one
//   taken at the edge that ends the done cycle. Reset: pools closed and counts
//   cleared at once; descriptors are written before read, so no clearing pass.
`default_nettype none

module first_fit_segment_allocator_unit
    import ffsa_pkg::*;
#(
    parameter int POOL_BYTES    = POOL_BYTES_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int CLUSTER_BYTES = CLUSTER_BYTES_DEF,
    parameter int MAX_POOLS     = MAX_POOLS_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                action,
    input  wire logic [REQ_W-1:0]    request_size,
    input  wire logic [ADDR_W-1:0]   free_address,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [ADDR_W-1:0]        granted_address
);

    localparam int PC    = POOL_BYTES / CLUSTER_BYTES;
    localparam int SZ_W  = $clog2(PC + 1);
    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOTS = TABLE_ENTRIES + 1;
    localparam int PO_W  = $clog2(MAX_POOLS + 1);
    localparam int PI_W  = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_LAUNCH,
        S_SCAN,
        S_UPDATE
    } state_t;

    state_t            state_reg;
    logic              action_reg;
    logic [SZ_MW-1:0]  n_reg;
    logic [PI_W-1:0]   fpool_reg;
    logic [SZ_MW-1:0]  target_reg;
    cmd_t              cmd_reg;
    logic [PI_W-1:0]   gpool_reg;
    logic [SZ_W-1:0]   goff_reg;
    logic [PO_W-1:0]   pools_reg;
    logic [IDX_W-1:0]  counts_reg [MAX_POOLS];
    logic              done_reg;
    status_t           status_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_by_pool;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;
    logic [DIV_W-1:0] n_cand;
    logic             pool_ok;

    // Cell chain
    logic  scan_bus [SLOTS+1];
    fit_t  fit_bus  [SLOTS+1][MAX_POOLS];
    hit_t  hit_bus  [SLOTS+1];
    slot_t own_s    [SLOTS];
    slot_t left_s   [SLOTS];
    slot_t r1_s     [SLOTS];
    slot_t r2_s     [SLOTS];
    logic [IDX_MW-1:0] cnt_ext [MAX_POOLS];
    logic [IDX_MW-1:0] fcount_ext;

    // Decision
    logic              sel_hit;
    logic [PI_W-1:0]   sel_q;
    fit_t              sel_fit;
    logic [IDX_W-1:0]  sel_count;
    hit_t              fh;
    logic [IDX_W-1:0]  fcount;
    logic [IDX_MW-1:0] f_lo;
    logic [1:0]        f_gap;
    logic [SZ_MW-1:0]  f_sum;
    logic [31:0]       grant_full;

    assign busy    = (state_reg != S_IDLE);
    assign n_cand  = (div_quo == '0) ? DIV_W'(1) : div_quo;
    assign pool_ok = (div_quo < DIV_W'(pools_reg));

    // Select divider operands: request rounding, pool split, cluster split
    always_comb
    begin
        div_start = ((state_reg == S_IDLE) && start)
                 || ((state_reg == S_DIV1) && div_done && action_reg && pool_ok);
        if (state_reg == S_IDLE)
        begin
            div_dividend = action ? DIV_W'(free_address)
                                  : DIV_W'(request_size) + DIV_W'(CLUSTER_BYTES - 1);
            div_by_pool  = action;
        end
        else
        begin
            div_dividend = div_rem;
            div_by_pool  = 1'b0;
        end
    end

    ffsa_div #(
        .DW            (DIV_W),
        .POOL_BYTES    (POOL_BYTES),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .by_pool   (div_by_pool),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Feed the head of the chain
    always_comb
    begin
        scan_bus[0] = (state_reg == S_LAUNCH);
        hit_bus[0]  = '0;
        for (int q = 0; q < MAX_POOLS; q++)
        begin
            fit_bus[0][q] = '0;
            cnt_ext[q]    = IDX_MW'(counts_reg[q]);
        end
        fcount_ext = IDX_MW'(counts_reg[fpool_reg]);
    end

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_l0
                assign left_s[k] = '0;
            end
            else
            begin : g_l1
                assign left_s[k] = own_s[k-1];
            end
            if (k + 1 < SLOTS)
            begin : g_r1a
                assign r1_s[k] = own_s[k+1];
            end
            else
            begin : g_r1b
                assign r1_s[k] = '0;
            end
            if (k + 2 < SLOTS)
            begin : g_r2a
                assign r2_s[k] = own_s[k+2];
            end
            else
            begin : g_r2b
                assign r2_s[k] = '0;
            end

            ffsa_cell #(
                .MAX_POOLS     (MAX_POOLS),
                .TABLE_ENTRIES (TABLE_ENTRIES),
                .POOL_CLUSTERS (PC),
                .CELL_IDX      (k)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .scan_in    (scan_bus[k]),
                .scan_out   (scan_bus[k+1]),
                .fit_in     (fit_bus[k]),
                .fit_out    (fit_bus[k+1]),
                .hit_in     (hit_bus[k]),
                .hit_out    (hit_bus[k+1]),
                .need       (n_reg),
                .counts     (cnt_ext),
                .free_pool  (POOL_MW'(fpool_reg)),
                .free_count (fcount_ext),
                .target     (target_reg),
                .cmd        (cmd_reg),
                .left       (left_s[k]),
                .right1     (r1_s[k]),
                .right2     (r2_s[k]),
                .own        (own_s[k])
            );
        end
    endgenerate

    // Pick the newest pool that fits, and work out the merge of a free
    always_comb
    begin
        sel_hit = 1'b0;
        sel_q   = '0;
        for (int q = 0; q < MAX_POOLS; q++)
        begin
            if (PO_W'(q) < pools_reg && (fit_bus[SLOTS][q].tail || fit_bus[SLOTS][q].found))
            begin
                sel_hit = 1'b1;
                sel_q   = PI_W'(q);
            end
        end
        sel_fit   = fit_bus[SLOTS][sel_q];
        sel_count = counts_reg[sel_q];

        fh     = hit_bus[SLOTS];
        fcount = counts_reg[fpool_reg];
        f_lo   = fh.lfree ? fh.idx - IDX_MW'(1) : fh.idx;
        f_gap  = 2'(fh.lfree) + 2'(fh.rfree);
        f_sum  = fh.csize + (fh.lfree ? fh.lsize : '0) + (fh.rfree ? fh.rsize : '0);
    end

    assign grant_full = 32'(gpool_reg) * 32'(POOL_BYTES)
                      + 32'(goff_reg) * 32'(CLUSTER_BYTES);

    // Sequence one word: decode, sweep, update, report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            action_reg <= 1'b0;
            n_reg      <= '0;
            fpool_reg  <= '0;
            target_reg <= '0;
            cmd_reg    <= '0;
            gpool_reg  <= '0;
            goff_reg   <= '0;
            pools_reg  <= '0;
            for (int q = 0; q < MAX_POOLS; q++)
            begin
                counts_reg[q] <= '0;
            end
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            addr_reg   <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            cmd_reg.op <= OP_NONE;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        action_reg <= action;
                        state_reg  <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        if (!action_reg)
                        begin
                            if (n_cand > DIV_W'(PC))
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= STATUS_NO_SPACE;
                                addr_reg   <= '0;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                n_reg     <= SZ_MW'(n_cand);
                                state_reg <= S_LAUNCH;
                            end
                        end
                        else if (!pool_ok)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= STATUS_BAD_ADDR;
                            addr_reg   <= '0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            fpool_reg <= div_quo[PI_W-1:0];
                            state_reg <= S_DIV2;
                        end
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        if (div_rem != '0)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= STATUS_BAD_ADDR;
                            addr_reg   <= '0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            target_reg <= SZ_MW'(div_quo);
                            state_reg  <= S_LAUNCH;
                        end
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_bus[SLOTS])
                    begin
                        if (!action_reg)
                        begin
                            if (sel_hit)
                            begin
                                gpool_reg   <= sel_q;
                                cmd_reg.pool <= POOL_MW'(sel_q);
                                cmd_reg.last <= IDX_MW'(sel_count);
                                cmd_reg.gap  <= 2'd0;
                                cmd_reg.val  <= n_reg;
                                state_reg    <= S_UPDATE;
                                if (sel_fit.tail)
                                begin
                                    cmd_reg.op  <= OP_SPLIT;
                                    cmd_reg.pos <= IDX_MW'(sel_count);
                                    goff_reg    <= sel_fit.toff[SZ_W-1:0];
                                    counts_reg[sel_q] <= sel_count + IDX_W'(1);
                                end
                                else if (sel_fit.exact || sel_count == IDX_W'(TABLE_ENTRIES))
                                begin
                                    cmd_reg.op  <= OP_EXACT;
                                    cmd_reg.pos <= sel_fit.idx;
                                    goff_reg    <= sel_fit.off[SZ_W-1:0];
                                end
                                else
                                begin
                                    cmd_reg.op  <= OP_SPLIT;
                                    cmd_reg.pos <= sel_fit.idx;
                                    goff_reg    <= sel_fit.off[SZ_W-1:0];
                                    counts_reg[sel_q] <= sel_count + IDX_W'(1);
                                end
                            end
                            else if (pools_reg < PO_W'(MAX_POOLS))
                            begin
                                cmd_reg.op   <= OP_NEW;
                                cmd_reg.pool <= POOL_MW'(pools_reg);
                                cmd_reg.pos  <= '0;
                                cmd_reg.last <= '0;
                                cmd_reg.gap  <= 2'd0;
                                cmd_reg.val  <= n_reg;
                                gpool_reg    <= pools_reg[PI_W-1:0];
                                goff_reg     <= '0;
                                counts_reg[pools_reg[PI_W-1:0]] <= IDX_W'(1);
                                pools_reg    <= pools_reg + PO_W'(1);
                                state_reg    <= S_UPDATE;
                            end
                            else
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= STATUS_NO_SPACE;
                                addr_reg   <= '0;
                                state_reg  <= S_IDLE;
                            end
                        end
                        else if (!fh.found)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= STATUS_BAD_ADDR;
                            addr_reg   <= '0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            cmd_reg.op   <= OP_FREE;
                            cmd_reg.pool <= POOL_MW'(fpool_reg);
                            cmd_reg.pos  <= f_lo;
                            cmd_reg.last <= IDX_MW'(fcount);
                            cmd_reg.gap  <= f_gap;
                            cmd_reg.val  <= f_sum;
                            counts_reg[fpool_reg] <= fcount - IDX_W'(f_gap);
                            state_reg    <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STATUS_OK;
                    addr_reg   <= action_reg ? '0 : grant_full[ADDR_W-1:0];
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = addr_reg;

    // Result strobe lasts one cycle and only leaves the block idle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result given while a word is still in work");

    a_cmd_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.op != OP_NONE) |-> (state_reg == S_UPDATE))
        else $error("table update broadcast outside the update step");

    a_pools_max: assert property (@(posedge clk) disable iff (!rst_n)
        pools_reg <= PO_W'(MAX_POOLS))
        else $error("more pools open than exist");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

endmodule

`default_nettype wire
